### rtl/apc_pkg.sv
// Shared constants for the annulus point classifier.
// No dependencies; used by the top level for defaults and register indexes.
package apc_pkg;

    // default coordinate format, signed Q16.16
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // tolerance register width
    localparam int TOL_WIDTH = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 3'd4;

endpackage

### rtl/apc_sqrt_cell.sv
// One cell of the integer square root chain: retires one root bit per cycle while i_en is high.
// Standalone; instantiated in a row by annulus_point_classify_project_core.
module apc_sqrt_cell #(
    parameter int W = 32
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [W+1:0]   i_rem,
    input  logic [W-1:0]   i_root,
    input  logic [2*W-1:0] i_n,
    output logic [W+1:0]   o_rem,
    output logic [W-1:0]   o_root,
    output logic [2*W-1:0] o_n
);

    logic [W+1:0]   n_rem;
    logic [W-1:0]   n_root;
    logic [W+1:0]   c_rem2;
    logic [W+1:0]   c_trial;
    logic [W+1:0]   r_rem;
    logic [W-1:0]   r_root;
    logic [2*W-1:0] r_n;

    // bring down two radicand bits, try appending a one to the root
    always_comb begin
        c_rem2  = {i_rem[W-1:0], i_n[2*W-1:2*W-2]};
        c_trial = {i_root, 2'b01};
        if (c_rem2 >= c_trial) begin
            n_rem  = c_rem2 - c_trial;
            n_root = {i_root[W-2:0], 1'b1};
        end else begin
            n_rem  = c_rem2;
            n_root = {i_root[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_n    <= {i_n[2*W-3:0], 2'b00};
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_n    = r_n;

endmodule

### rtl/apc_div_cell.sv
// One cell of the restoring divider chain: retires one quotient bit per cycle while i_en is high.
// Standalone; instantiated in a row by annulus_point_classify_project_core.
module apc_div_cell #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_rem,
    input  logic [W-2:0] i_low,
    input  logic [W-2:0] i_q,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_rem,
    output logic [W-2:0] o_low,
    output logic [W-2:0] o_q,
    output logic [W-1:0] o_d
);

    logic [W:0]   c_sh;
    logic [W-1:0] n_rem;
    logic [W-2:0] n_q;
    logic [W-1:0] r_rem;
    logic [W-2:0] r_low;
    logic [W-2:0] r_q;
    logic [W-1:0] r_d;

    // shift in the next dividend bit, subtract the divisor if it fits
    always_comb begin
        c_sh = {i_rem, i_low[W-2]};
        if (c_sh >= {1'b0, i_d}) begin
            n_rem = W'(c_sh - {1'b0, i_d});
            n_q   = {i_q[W-3:0], 1'b1};
        end else begin
            n_rem = c_sh[W-1:0];
            n_q   = {i_q[W-3:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_low <= {i_low[W-3:0], 1'b0};
            r_q   <= n_q;
            r_d   <= i_d;
        end
    end

    assign o_rem = r_rem;
    assign o_low = r_low;
    assign o_q   = r_q;
    assign o_d   = r_d;

endmodule

### rtl/annulus_point_classify_project_core.sv
// Annulus slab point classifier and projector, top level.
// Throughput: one item per cycle unless stalled; a square root row and two divider rows of cells.
// The whole row stalls only while a result waits and the output is not ready.
// Reset (synchronous, active low) clears valids and loads register defaults.
// Depends on apc_pkg, apc_sqrt_cell and apc_div_cell.
module annulus_point_classify_project_core #(
    parameter int COORD_WIDTH = apc_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = apc_pkg::FRAC_BITS_DEF,
    parameter int IN_W        = ((4*COORD_WIDTH - 1 + 7) / 8) * 8,
    parameter int OUT_W       = ((3*COORD_WIDTH + 3 + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [apc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data,
    // input: pos_x, pos_y, pos_z, probe_radius (lowest bits first)
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [IN_W-1:0]               s_axis_tdata,
    // output: is_inside, sphere_inside, proj_x, proj_y, proj_z, setting_invalid
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [OUT_W-1:0]              m_axis_tdata
);

    localparam int W   = COORD_WIDTH;
    localparam int TW  = apc_pkg::TOL_WIDTH;
    localparam int S1W = 4*W - 1;         // x, y, z, probe
    localparam int S2W = 2*W + 4;         // sx, sy, nz, ins, sph, pz, t

    // configuration registers
    logic [W-2:0]  r_outer, r_inner;
    logic [W-1:0]  r_bottom, r_top;
    logic [TW-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer  <= (W-1)'(1) << FRAC_BITS;
            r_inner  <= '0;
            r_bottom <= '0;
            r_top    <= '0;
            r_tol    <= TW'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                apc_pkg::CFG_OUTER:  r_outer  <= i_cfg_data[W-2:0];
                apc_pkg::CFG_INNER:  r_inner  <= i_cfg_data[W-2:0];
                apc_pkg::CFG_BOTTOM: r_bottom <= i_cfg_data;
                apc_pkg::CFG_TOP:    r_top    <= i_cfg_data;
                apc_pkg::CFG_TOL:    r_tol    <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // sorted slab bounds
    logic [W-1:0] c_lo, c_hi;
    always_comb begin
        if ($signed(r_bottom) < $signed(r_top)) begin
            c_lo = r_bottom;
            c_hi = r_top;
        end else begin
            c_lo = r_top;
            c_hi = r_bottom;
        end
    end

    // pipeline advance
    logic r_o_v;
    logic c_en;
    assign c_en          = !r_o_v || m_axis_tready;
    assign s_axis_tready = c_en;

    // stage A: input register
    logic         r_a_v;
    logic [S1W-1:0] r_a_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_a_v <= 1'b0;
        else if (c_en) r_a_v <= s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (c_en) r_a_d <= s_axis_tdata[S1W-1:0];
    end

    // stage B: squares of the magnitudes
    logic [W-1:0]   c_ax, c_ay, c_mx, c_my;
    logic [2*W-1:0] r_b_sqx, r_b_sqy, r_c_sum;
    assign c_ax = r_a_d[W-1:0];
    assign c_ay = r_a_d[2*W-1:W];
    assign c_mx = c_ax[W-1] ? W'(-c_ax) : c_ax;
    assign c_my = c_ay[W-1] ? W'(-c_ay) : c_ay;

    // side data line and valids, B and C then one slot per sqrt cell
    logic [S1W-1:0] r_side1 [0:W+1];
    logic           r_v1    [0:W+1];

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_b_sqx <= c_mx * c_mx;
            r_b_sqy <= c_my * c_my;
            r_c_sum <= r_b_sqx + r_b_sqy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= W+1; k++) r_v1[k] <= 1'b0;
        end else if (c_en) begin
            r_v1[0] <= r_a_v;
            for (int k = 1; k <= W+1; k++) r_v1[k] <= r_v1[k-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_side1[0] <= r_a_d;
            for (int k = 1; k <= W+1; k++) r_side1[k] <= r_side1[k-1];
        end
    end

    // square root row
    logic [W+1:0]   sq_rem  [0:W];
    logic [W-1:0]   sq_root [0:W];
    logic [2*W-1:0] sq_n    [0:W];
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_n[0]    = r_c_sum;

    for (genvar k = 0; k < W; k++) begin : g_sqrt
        apc_sqrt_cell #(.W(W)) u_cell (
            .i_clk  (i_clk),
            .i_en   (c_en),
            .i_rem  (sq_rem[k]),
            .i_root (sq_root[k]),
            .i_n    (sq_n[k]),
            .o_rem  (sq_rem[k+1]),
            .o_root (sq_root[k+1]),
            .o_n    (sq_n[k+1])
        );
    end

    // stage T: classify, choose target rim, clamp z
    logic [S1W-1:0] c_s1;
    logic [W-1:0]   c_r, c_x, c_y, c_z;
    logic [W-2:0]   c_prb;
    logic signed [W+1:0] c_rs, c_in, c_out, c_tl, c_pb, c_zs, c_los, c_his;
    logic           n_ins, n_sph, n_nz;
    logic [W-2:0]   n_t;
    logic [W-1:0]   n_pz;

    assign c_s1  = r_side1[W+1];
    assign c_r   = sq_root[W];
    assign c_x   = c_s1[W-1:0];
    assign c_y   = c_s1[2*W-1:W];
    assign c_z   = c_s1[3*W-1:2*W];
    assign c_prb = c_s1[4*W-2:3*W];

    always_comb begin
        c_rs  = {2'b00, c_r};
        c_in  = {3'b000, r_inner};
        c_out = {3'b000, r_outer};
        c_tl  = {{(W+2-TW){1'b0}}, r_tol};
        c_pb  = {3'b000, c_prb};
        c_zs  = {{2{c_z[W-1]}}, c_z};
        c_los = {{2{c_lo[W-1]}}, c_lo};
        c_his = {{2{c_hi[W-1]}}, c_hi};
        n_ins = (c_zs >= c_los) && (c_zs <= c_his)
             && (c_rs >= c_in - c_tl) && (c_rs <= c_out + c_tl);
        n_sph = (c_zs >= c_los + c_pb) && (c_zs <= c_his - c_pb)
             && (c_rs >= c_in + c_pb) && (c_rs <= c_out - c_pb);
        if (c_rs < c_in)
            n_t = r_inner;
        else if (c_rs > c_out)
            n_t = r_outer;
        else if ({1'b0, c_r, 1'b0} <= {2'b00, r_inner} + {2'b00, r_outer})
            n_t = r_inner;       // tie goes to inner rim
        else
            n_t = r_outer;
        n_nz = c_rs <= c_tl;
        if (c_zs < c_los)      n_pz = c_lo;
        else if (c_zs > c_his) n_pz = c_hi;
        else                   n_pz = c_z;
    end

    logic           r_t_v;
    logic [W-1:0]   r_t_r, r_t_mx, r_t_my;
    logic [S2W-1:0] r_t_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_t_v <= 1'b0;
        else if (c_en) r_t_v <= r_v1[W+1];
    end
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_t_r    <= c_r;
            r_t_mx   <= c_x[W-1] ? W'(-c_x) : c_x;
            r_t_my   <= c_y[W-1] ? W'(-c_y) : c_y;
            r_t_side <= {c_x[W-1], c_y[W-1], n_nz, n_ins, n_sph, n_pz, n_t};
        end
    end

    // stage M: magnitude times target radius
    logic [2*W-2:0] r_m_nx, r_m_ny;
    logic [W-1:0]   r_m_r;
    logic [S2W-1:0] r_side2 [0:W-1];
    logic           r_v2    [0:W-1];

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_m_nx <= (2*W-1)'(r_t_mx * r_t_side[W-2:0]);
            r_m_ny <= (2*W-1)'(r_t_my * r_t_side[W-2:0]);
            r_m_r  <= r_t_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < W; k++) r_v2[k] <= 1'b0;
        end else if (c_en) begin
            r_v2[0] <= r_t_v;
            for (int k = 1; k < W; k++) r_v2[k] <= r_v2[k-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_side2[0] <= r_t_side;
            for (int k = 1; k < W; k++) r_side2[k] <= r_side2[k-1];
        end
    end

    // divider rows, one lane per axis
    logic [W-1:0] dx_rem [0:W-1], dy_rem [0:W-1];
    logic [W-2:0] dx_low [0:W-1], dy_low [0:W-1];
    logic [W-2:0] dx_q   [0:W-1], dy_q   [0:W-1];
    logic [W-1:0] dx_d   [0:W-1], dy_d   [0:W-1];

    assign dx_rem[0] = r_m_nx[2*W-2:W-1];
    assign dx_low[0] = r_m_nx[W-2:0];
    assign dx_q[0]   = '0;
    assign dx_d[0]   = r_m_r;
    assign dy_rem[0] = r_m_ny[2*W-2:W-1];
    assign dy_low[0] = r_m_ny[W-2:0];
    assign dy_q[0]   = '0;
    assign dy_d[0]   = r_m_r;

    for (genvar k = 0; k < W-1; k++) begin : g_div
        apc_div_cell #(.W(W)) u_x (
            .i_clk (i_clk), .i_en (c_en),
            .i_rem (dx_rem[k]), .i_low (dx_low[k]), .i_q (dx_q[k]), .i_d (dx_d[k]),
            .o_rem (dx_rem[k+1]), .o_low (dx_low[k+1]), .o_q (dx_q[k+1]),
            .o_d   (dx_d[k+1])
        );
        apc_div_cell #(.W(W)) u_y (
            .i_clk (i_clk), .i_en (c_en),
            .i_rem (dy_rem[k]), .i_low (dy_low[k]), .i_q (dy_q[k]), .i_d (dy_d[k]),
            .o_rem (dy_rem[k+1]), .o_low (dy_low[k+1]), .o_q (dy_q[k+1]),
            .o_d   (dy_d[k+1])
        );
    end

    // output stage: round half up, apply sign, near-zero override
    logic [S2W-1:0] c_s2;
    logic [W-2:0]   c_qx, c_qy;
    logic [W-1:0]   n_px, n_py;
    assign c_s2 = r_side2[W-1];

    always_comb begin
        c_qx = dx_q[W-1] + (({dx_rem[W-1], 1'b0} >= {1'b0, dx_d[W-1]}) ? 1'b1 : 1'b0);
        c_qy = dy_q[W-1] + (({dy_rem[W-1], 1'b0} >= {1'b0, dy_d[W-1]}) ? 1'b1 : 1'b0);
        if (c_s2[2*W+1]) begin
            n_px = {1'b0, c_s2[W-2:0]};
            n_py = '0;
        end else begin
            n_px = c_s2[2*W+3] ? W'(-{1'b0, c_qx}) : {1'b0, c_qx};
            n_py = c_s2[2*W+2] ? W'(-{1'b0, c_qy}) : {1'b0, c_qy};
        end
    end

    logic r_o_ins, r_o_sph;
    logic [W-1:0] r_o_px, r_o_py, r_o_pz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_o_v <= 1'b0;
        else if (c_en) r_o_v <= r_v2[W-1];
    end
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_o_ins <= c_s2[2*W];
            r_o_sph <= c_s2[2*W-1];
            r_o_pz  <= c_s2[2*W-2:W-1];
            r_o_px  <= n_px;
            r_o_py  <= n_py;
        end
    end

    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = OUT_W'({r_outer <= r_inner, r_o_pz, r_o_py, r_o_px,
                                   r_o_sph, r_o_ins});

`ifndef SYNTHESIS
    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a sphere wholly inside implies its center is inside
    a_sph_implies_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_o_sph) |-> r_o_ins)
        else $error("sphere_inside without is_inside");

    // projected z stays within the sorted slab
    a_pz_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(r_o_pz) >= $signed(c_lo)
                           && $signed(r_o_pz) <= $signed(c_hi)))
        else $error("proj_z outside slab");

    // a stalled result is held while the row is frozen
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(m_axis_tvalid) && !$past(m_axis_tready)) |-> $stable(r_o_px))
        else $error("result changed under stall");
`endif

endmodule
